// ----- hdl/byte_ring_buffer_engine_defines.svh -----
// Assertion helpers for the byte ring buffer engine.
// BRB_ASSERT expects signals named clk and rst_n in the scope of use, BRB_ASSERT_ALWAYS only clk.
`ifndef BYTE_RING_BUFFER_ENGINE_DEFINES_SVH
`define BYTE_RING_BUFFER_ENGINE_DEFINES_SVH

// Checked on every rising edge outside reset.
`define BRB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BRB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/brb_pkg.sv -----
// ----------------------------------------------------------------------------
// Byte ring buffer package
// Shared widths, the default ring depth and the command codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package brb_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int CMD_W   = 3;
  localparam int DATA_W  = 8;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;
  localparam int FILL_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_POP_FRONT  = 3'd1,
    CMD_DROP_FRONT = 3'd2,
    CMD_PEEK       = 3'd3,
    CMD_PUSH_FRONT = 3'd4,
    CMD_REMOVE_MID = 3'd5,
    CMD_CLEAR      = 3'd6
  } cmd_t;

endpackage

`default_nettype wire

// ----- hdl/byte_ring_buffer_engine.sv -----
// ----------------------------------------------------------------------------
// Byte ring buffer engine
// Circular byte FIFO with push/pop at both ends, peek, drop, middle removal
// and clear, reporting fill status for every transaction.
// ----------------------------------------------------------------------------
// Every input transaction yields exactly one result transaction that carries
// the byte read (pop and peek only), the fill level and free space after the
// command, the empty and full flags and a refused flag for a push that found
// no room. Push_back, push_front, drop_front, clear, and pop or peek that find
// nothing to read complete without a memory read, so one such transaction is
// taken per clock while the result register is free or being emptied. A pop or
// a peek that reads a stored byte passes through a read state, because the byte
// store is a synchronous memory with a registered read port. Remove_middle
// reports its status at once and then shifts the later bytes down through the
// memory, one byte per cycle, with each byte written after it is read; the
// block stays in the shift state until the last byte is written, and no input
// transaction is taken during the shift. The result sits in an output
// register, so a new input transaction is taken while the previous result
// is being handed over. The byte store needs no clearing after reset, since
// only bytes held in the ring are ever read.
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_buffer_engine #(
  parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // Command channel
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [brb_pkg::CMD_W-1:0]    in_cmd,
  input  wire  [brb_pkg::DATA_W-1:0]   in_data_byte,
  input  wire  [brb_pkg::INDEX_W-1:0]  in_index,
  input  wire  [brb_pkg::COUNT_W-1:0]  in_count,
  // Result channel
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [brb_pkg::DATA_W-1:0]   out_read_data,
  output logic [brb_pkg::FILL_W-1:0]   out_fill_level,
  output logic [brb_pkg::FILL_W-1:0]   out_free_space,
  output logic                         out_is_empty,
  output logic                         out_is_full,
  output logic                         out_refused
);

  // Slot pointers are AW bits wide; fill counts need one more bit so that a
  // full ring can be told apart from an empty one.
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = AW + 1;
  localparam int CMPW = (CW > brb_pkg::COUNT_W) ? CW : brb_pkg::COUNT_W;
  localparam int DW   = brb_pkg::DATA_W;
  localparam int FW   = brb_pkg::FILL_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHIFT
  } state_t;

  brb_pkg::cmd_t cmd;

  state_t         state_r, state_nxt;
  logic [AW-1:0]  head_r, head_nxt;
  logic [AW-1:0]  tail_r, tail_nxt;
  logic           empty_r, empty_nxt;

  // Shift engine for remove_middle: source and destination pointers, bytes
  // still to be read, and a flag marking a read whose data must be written.
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]  left_r, left_nxt;
  logic           pend_r, pend_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic [DW-1:0]  out_read_data_r, out_read_data_nxt;
  logic [FW-1:0]  out_fill_level_r, out_fill_level_nxt;
  logic [FW-1:0]  out_free_space_r, out_free_space_nxt;
  logic           out_is_empty_r, out_is_empty_nxt;
  logic           out_is_full_r, out_is_full_nxt;
  logic           out_refused_r, out_refused_nxt;

  // Byte store and its port signals.
  logic [DW-1:0]  mem [DEPTH];
  logic [DW-1:0]  mem_rdata_r;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [DW-1:0]  mem_wdata;
  logic [AW-1:0]  mem_raddr;

  logic           in_accept;
  logic [CW-1:0]  fill;
  logic           full;
  logic [CW-1:0]  drop_len;
  logic           peek_hit;
  logic [AW-1:0]  rm_s;
  logic           rm_hit;
  logic [CW-1:0]  rm_avail;
  logic [CW-1:0]  rm_len;

  assign cmd = brb_pkg::cmd_t'(in_cmd);

  // The block only takes a transaction while idle and when the output
  // register is free or being emptied at this edge.
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_accept = in_valid && in_ready;

  // Current fill level. Equal pointers mean empty or full, told apart by
  // the empty mark.
  assign fill = (head_r == tail_r) ? (empty_r ? '0 : DEPTH_C)
                                   : CW'(AW'(tail_r - head_r));
  assign full = (fill == DEPTH_C);

  // Drop saturates at the number of bytes held.
  assign drop_len = (CMPW'(in_count) < CMPW'(fill)) ? CW'(in_count) : fill;

  assign peek_hit = (CMPW'(in_index) < CMPW'(fill));

  // Remove_middle takes an absolute start slot; its distance from the head
  // decides whether it lies inside the held bytes, and the length is cut
  // to the bytes between the start slot and the tail.
  assign rm_s     = AW'(in_index) - head_r;
  assign rm_hit   = (CW'(rm_s) < fill);
  assign rm_avail = fill - CW'(rm_s);
  assign rm_len   = (CMPW'(in_count) < CMPW'(rm_avail)) ? CW'(in_count) : rm_avail;

  always_comb begin
    logic [CW-1:0] fill_nxt;
    logic          done_now;
    logic          refused;

    state_nxt          = state_r;
    head_nxt           = head_r;
    tail_nxt           = tail_r;
    empty_nxt          = empty_r;
    rd_ptr_nxt         = rd_ptr_r;
    wr_ptr_nxt         = wr_ptr_r;
    left_nxt           = left_r;
    pend_nxt           = 1'b0;
    out_valid_nxt      = out_valid_r && !out_ready;
    out_read_data_nxt  = out_read_data_r;
    out_fill_level_nxt = out_fill_level_r;
    out_free_space_nxt = out_free_space_r;
    out_is_empty_nxt   = out_is_empty_r;
    out_is_full_nxt    = out_is_full_r;
    out_refused_nxt    = out_refused_r;
    mem_we             = 1'b0;
    mem_waddr          = tail_r;
    mem_wdata          = in_data_byte;
    mem_raddr          = rd_ptr_r;
    fill_nxt           = fill;
    done_now           = 1'b1;
    refused            = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          case (cmd)
            brb_pkg::CMD_PUSH_BACK: begin
              if (full) begin
                refused = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = tail_r;
                tail_nxt  = tail_r + AW'(1);
                empty_nxt = 1'b0;
                fill_nxt  = fill + CW'(1);
              end
            end
            brb_pkg::CMD_POP_FRONT: begin
              if (fill != '0) begin
                mem_raddr = head_r;
                head_nxt  = head_r + AW'(1);
                empty_nxt = ((head_r + AW'(1)) == tail_r);
                fill_nxt  = fill - CW'(1);
                done_now  = 1'b0;
                state_nxt = S_READ;
              end
            end
            brb_pkg::CMD_DROP_FRONT: begin
              if (drop_len != '0) begin
                head_nxt  = head_r + AW'(drop_len);
                empty_nxt = (drop_len == fill);
                fill_nxt  = fill - drop_len;
              end
            end
            brb_pkg::CMD_PEEK: begin
              if (peek_hit) begin
                mem_raddr = head_r + AW'(in_index);
                done_now  = 1'b0;
                state_nxt = S_READ;
              end
            end
            brb_pkg::CMD_PUSH_FRONT: begin
              if (full) begin
                refused = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = head_r - AW'(1);
                head_nxt  = head_r - AW'(1);
                empty_nxt = 1'b0;
                fill_nxt  = fill + CW'(1);
              end
            end
            brb_pkg::CMD_REMOVE_MID: begin
              if (rm_hit && (rm_len != '0)) begin
                tail_nxt   = tail_r - AW'(rm_len);
                empty_nxt  = (rm_len == fill);
                fill_nxt   = fill - rm_len;
                rd_ptr_nxt = AW'(in_index) + AW'(rm_len);
                wr_ptr_nxt = AW'(in_index);
                left_nxt   = rm_avail - rm_len;
                if ((rm_avail - rm_len) != '0) begin
                  state_nxt = S_SHIFT;
                end
              end
            end
            brb_pkg::CMD_CLEAR: begin
              head_nxt  = tail_r;
              empty_nxt = 1'b1;
              fill_nxt  = '0;
            end
            default: begin
            end
          endcase

          out_valid_nxt      = done_now;
          out_read_data_nxt  = '0;
          out_fill_level_nxt = FW'(fill_nxt);
          out_free_space_nxt = FW'(DEPTH_C - fill_nxt);
          out_is_empty_nxt   = (fill_nxt == '0);
          out_is_full_nxt    = (fill_nxt == DEPTH_C);
          out_refused_nxt    = refused;
        end
      end

      S_READ: begin
        // The status fields were loaded at accept; only the byte arrives now.
        out_read_data_nxt = mem_rdata_r;
        out_valid_nxt     = 1'b1;
        state_nxt         = S_IDLE;
      end

      S_SHIFT: begin
        // Reads run one slot ahead of writes; the destination always trails
        // the source, so a pending write never hits a slot still to be read.
        if (left_r != '0) begin
          mem_raddr  = rd_ptr_r;
          rd_ptr_nxt = rd_ptr_r + AW'(1);
          left_nxt   = left_r - CW'(1);
          pend_nxt   = 1'b1;
        end
        if (pend_r) begin
          mem_we     = 1'b1;
          mem_waddr  = wr_ptr_r;
          mem_wdata  = mem_rdata_r;
          wr_ptr_nxt = wr_ptr_r + AW'(1);
        end
        if (left_r == '0) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      left_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      empty_r     <= empty_nxt;
      left_r      <= left_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_ptr_r         <= rd_ptr_nxt;
    wr_ptr_r         <= wr_ptr_nxt;
    out_read_data_r  <= out_read_data_nxt;
    out_fill_level_r <= out_fill_level_nxt;
    out_free_space_r <= out_free_space_nxt;
    out_is_empty_r   <= out_is_empty_nxt;
    out_is_full_r    <= out_is_full_nxt;
    out_refused_r    <= out_refused_nxt;
  end

  // Byte store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = out_read_data_r;
  assign out_fill_level = out_fill_level_r;
  assign out_free_space = out_free_space_r;
  assign out_is_empty   = out_is_empty_r;
  assign out_is_full    = out_is_full_r;
  assign out_refused    = out_refused_r;

endmodule

`default_nettype wire

// ----- hdl/brb_checker.sv -----
// ----------------------------------------------------------------------------
// Byte ring buffer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "byte_ring_buffer_engine_defines.svh"

module brb_checker #(
  parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [brb_pkg::DATA_W-1:0]    out_read_data,
  input wire [brb_pkg::FILL_W-1:0]    out_fill_level,
  input wire [brb_pkg::FILL_W-1:0]    out_free_space,
  input wire                          out_is_empty,
  input wire                          out_is_full,
  input wire                          out_refused
);

  localparam int FW = brb_pkg::FILL_W;

  // A stalled result must hold its byte.
  `BRB_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_read_data)), "result changed while stalled")

  // Fill level and free space always add up to the ring depth.
  `BRB_ASSERT(a_fill_sum, out_valid |-> ((out_fill_level + out_free_space) == FW'(DEPTH)), "fill level and free space disagree")

  // A refused push only happens on a full ring, which is never empty.
  `BRB_ASSERT(a_refused_full, (out_valid && out_refused) |-> (out_is_full && !out_is_empty), "refusal without a full ring")

  // Nothing is offered in the cycle after reset, and no input is taken twice
  // while a result is stuck.
  `BRB_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result offered after reset")

  `BRB_ASSERT(a_no_take_stuck, (out_valid && !out_ready) |-> !(in_valid && in_ready && $past(in_valid && in_ready && out_valid && !out_ready)), "input taken twice while result stalled")

endmodule

bind byte_ring_buffer_engine brb_checker #(.DEPTH(DEPTH)) u_brb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_read_data  (out_read_data),
  .out_fill_level (out_fill_level),
  .out_free_space (out_free_space),
  .out_is_empty   (out_is_empty),
  .out_is_full    (out_is_full),
  .out_refused    (out_refused)
);

`default_nettype wire

// ----- test/tb_byte_ring_buffer_engine.sv -----
// ----------------------------------------------------------------------------
// Byte ring buffer engine testbench
// Drives command transactions through the valid/ready handshake, predicts
// every status transaction from a shadow ring and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_byte_ring_buffer_engine;

  localparam int DEPTH        = brb_pkg::DEPTH_DEF;
  localparam int SLOT_W       = brb_pkg::INDEX_W;
  localparam int CNT_W        = brb_pkg::COUNT_W;
  localparam int BYTE_W       = brb_pkg::DATA_W;
  localparam int IDLE_PCT     = 31;
  localparam int RESET_CYCLES = 4;
  // The drain at the end leaves comfortably more time than the longest
  // remove_middle shift.
  localparam int DRAIN_CYCLES = 2 * DEPTH + 16;
  localparam int CYCLE_LIMIT  = 400000;
  // Window of the run in which neither side idles.
  localparam int CALM_START   = 2000;
  localparam int CALM_END     = 3500;
  localparam int RANDOM_ITEMS = 1930;
  localparam int MODE_SPAN    = 128;

  // Command code seven is not decoded by the block and must change nothing.
  localparam logic [brb_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;

  // Traffic shapes for the random part.
  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIX   = 2;

  typedef struct packed {
    logic [brb_pkg::CMD_W-1:0]   cmd;
    logic [brb_pkg::DATA_W-1:0]  data;
    logic [brb_pkg::INDEX_W-1:0] index;
    logic [brb_pkg::COUNT_W-1:0] count;
  } ring_cmd_t;

  typedef struct packed {
    logic [brb_pkg::DATA_W-1:0] read_data;
    logic [brb_pkg::FILL_W-1:0] fill_level;
    logic [brb_pkg::FILL_W-1:0] free_space;
    logic                       is_empty;
    logic                       is_full;
    logic                       refused;
  } ring_status_t;

  // Shadow of the ring: byte slots, head (oldest byte), tail (next free slot)
  // and the empty mark that separates a full ring from an empty one.
  typedef struct packed {
    logic [DEPTH-1:0][brb_pkg::DATA_W-1:0] store;
    logic [SLOT_W-1:0]                     head;
    logic [SLOT_W-1:0]                     tail;
    logic                                  empty;
  } ring_state_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                        in_valid     = 1'b0;
  logic                        in_ready;
  logic [brb_pkg::CMD_W-1:0]   in_cmd       = brb_pkg::CMD_CLEAR;
  logic [brb_pkg::DATA_W-1:0]  in_data_byte = '0;
  logic [brb_pkg::INDEX_W-1:0] in_index     = '0;
  logic [brb_pkg::COUNT_W-1:0] in_count     = '0;

  logic                        out_valid;
  logic                        out_ready    = 1'b0;
  logic [brb_pkg::DATA_W-1:0]  out_read_data;
  logic [brb_pkg::FILL_W-1:0]  out_fill_level;
  logic [brb_pkg::FILL_W-1:0]  out_free_space;
  logic                        out_is_empty;
  logic                        out_is_full;
  logic                        out_refused;

  ring_cmd_t    cmd_q[$];      // commands waiting to be offered
  ring_status_t status_q[$];   // predicted status of accepted commands
  ring_state_t  live_ring;     // shadow advanced on each accepted command
  ring_state_t  gen_ring;      // shadow used while the stimulus is built
  ring_cmd_t    cur_cmd;       // command currently on the input channel
  int unsigned  cycle_cnt  = 0;
  int unsigned  mismatches = 0;
  logic         calm;

  assign calm = (cycle_cnt >= CALM_START) && (cycle_cnt < CALM_END);

  byte_ring_buffer_engine #(
    .DEPTH(DEPTH)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_data_byte  (in_data_byte),
    .in_index      (in_index),
    .in_count      (in_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_data (out_read_data),
    .out_fill_level(out_fill_level),
    .out_free_space(out_free_space),
    .out_is_empty  (out_is_empty),
    .out_is_full   (out_is_full),
    .out_refused   (out_refused)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bytes held: when head meets tail the empty mark decides between none and
  // a full ring; otherwise the distance wraps naturally at the slot width.
  function automatic int unsigned ring_fill(ring_state_t r);
    logic [SLOT_W-1:0] span;
    span = r.tail - r.head;
    if (r.head == r.tail) begin
      return r.empty ? 0 : DEPTH;
    end
    return 32'(span);
  endfunction

  // Applies one command to a shadow ring and returns the status the block
  // must report for it.
  function automatic ring_status_t step_ring(inout ring_state_t r, input ring_cmd_t c);
    ring_status_t      st;
    int unsigned       n;
    int unsigned       len;
    int unsigned       start;
    int unsigned       k;
    int unsigned       left;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] src;
    n  = ring_fill(r);
    st = '0;
    case (c.cmd)
      brb_pkg::CMD_PUSH_BACK: begin
        if (n >= DEPTH) begin
          st.refused = 1'b1;
        end else begin
          r.store[r.tail] = c.data;
          r.tail          = r.tail + 1'b1;
          r.empty         = 1'b0;
        end
      end
      brb_pkg::CMD_POP_FRONT: begin
        if (n > 0) begin
          st.read_data = r.store[r.head];
          r.head       = r.head + 1'b1;
          if (r.head == r.tail) r.empty = 1'b1;
        end
      end
      brb_pkg::CMD_DROP_FRONT: begin
        // Dropping more than is held only empties the ring.
        len = (32'(c.count) < n) ? 32'(c.count) : n;
        if (len > 0) begin
          r.head = r.head + len[SLOT_W-1:0];
          if (r.head == r.tail) r.empty = 1'b1;
        end
      end
      brb_pkg::CMD_PEEK: begin
        if (32'(c.index) < n) begin
          slot         = r.head + c.index;
          st.read_data = r.store[slot];
        end
      end
      brb_pkg::CMD_PUSH_FRONT: begin
        // Exactly one byte goes in front of the head; count plays no part.
        if (n >= DEPTH) begin
          st.refused = 1'b1;
        end else begin
          r.head          = r.head - 1'b1;
          r.store[r.head] = c.data;
          r.empty         = 1'b0;
        end
      end
      brb_pkg::CMD_REMOVE_MID: begin
        // The index is an absolute slot; it only counts when it lies among
        // the held bytes, and the run is cut at the tail.
        slot  = c.index - r.head;
        start = 32'(slot);
        if (start < n) begin
          left = n - start;
          len  = (32'(c.count) < left) ? 32'(c.count) : left;
          if (len > 0) begin
            for (k = start; k + len < n; k++) begin
              slot          = r.head + k[SLOT_W-1:0];
              src           = slot + len[SLOT_W-1:0];
              r.store[slot] = r.store[src];
            end
            r.tail = r.tail - len[SLOT_W-1:0];
            if (n == len) r.empty = 1'b1;
          end
        end
      end
      brb_pkg::CMD_CLEAR: begin
        r.head  = r.tail;
        r.empty = 1'b1;
      end
      default: begin
      end
    endcase
    n             = ring_fill(r);
    left          = DEPTH - n;
    st.fill_level = n[brb_pkg::FILL_W-1:0];
    st.free_space = left[brb_pkg::FILL_W-1:0];
    st.is_empty   = (n == 0);
    st.is_full    = (n == DEPTH);
    return st;
  endfunction

  // Queues one command and advances the build-time shadow, so that later
  // random commands can aim their offsets at bytes that are really held.
  task automatic add_item(input logic [brb_pkg::CMD_W-1:0] op,
                          input logic [brb_pkg::DATA_W-1:0] data,
                          input logic [brb_pkg::INDEX_W-1:0] index,
                          input logic [brb_pkg::COUNT_W-1:0] count);
    ring_cmd_t it;
    it.cmd   = op;
    it.data  = data;
    it.index = index;
    it.count = count;
    void'(step_ring(gen_ring, it));
    cmd_q.push_back(it);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Driver. A new command is offered only when the channel is free or the
  // current one is being taken at this edge, so valid never drops while a
  // transaction is pending and each edge makes one assignment to it. The
  // prediction is made at the edge where the block accepts the command.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        status_q.push_back(step_ring(live_ring, cur_cmd));
      end
      if (!in_valid || in_ready) begin
        if (cmd_q.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_cmd      = cmd_q.pop_front();
          in_valid     <= 1'b1;
          in_cmd       <= cur_cmd.cmd;
          in_data_byte <= cur_cmd.data;
          in_index     <= cur_cmd.index;
          in_count     <= cur_cmd.count;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every status transaction taken is compared with the oldest
  // prediction; ready is dropped at random to stall the result channel.
  always @(posedge clk) begin
    ring_status_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          $display("%0t ns: unexpected status transaction, expected none, actual fill %0d",
                   $time, out_fill_level);
          mismatches++;
        end else begin
          want = status_q.pop_front();
          check_field("read_data", 32'(want.read_data), 32'(out_read_data));
          check_field("fill_level", 32'(want.fill_level), 32'(out_fill_level));
          check_field("free_space", 32'(want.free_space), 32'(out_free_space));
          check_field("is_empty", 32'(want.is_empty), 32'(out_is_empty));
          check_field("is_full", 32'(want.is_full), 32'(out_is_full));
          check_field("refused", 32'(want.refused), 32'(out_refused));
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int                          i;
    int                          mode;
    int                          roll;
    int unsigned                 fill;
    bit                          noise;
    logic [brb_pkg::CMD_W-1:0]   op;
    logic [brb_pkg::INDEX_W-1:0] idx;
    logic [brb_pkg::COUNT_W-1:0] cnt;

    live_ring       = '0;
    live_ring.empty = 1'b1;
    gen_ring        = live_ring;
    mode            = MODE_MIX;

    // Directed part. On an empty ring: pop and peek read nothing, a drop of
    // everything and a middle removal do nothing.
    add_item(brb_pkg::CMD_POP_FRONT, 8'h00, 6'd0, 7'd0);
    add_item(brb_pkg::CMD_PEEK, 8'hFF, 6'd0, 7'd0);
    add_item(brb_pkg::CMD_DROP_FRONT, 8'h00, 6'd0, 7'd64);
    add_item(brb_pkg::CMD_REMOVE_MID, 8'h00, 6'd0, 7'd1);
    // Both byte extremes at the back, two bytes in front; count is ignored
    // by push_front, so it is given both extremes.
    add_item(brb_pkg::CMD_PUSH_BACK, 8'h00, 6'd63, 7'd0);
    add_item(brb_pkg::CMD_PUSH_BACK, 8'hFF, 6'd0, 7'd64);
    add_item(brb_pkg::CMD_PUSH_FRONT, 8'hA5, 6'd0, 7'd64);
    add_item(brb_pkg::CMD_PUSH_FRONT, 8'h5A, 6'd63, 7'd0);
    // Peeks within the held bytes and beyond them.
    add_item(brb_pkg::CMD_PEEK, 8'h00, 6'd0, 7'd0);
    add_item(brb_pkg::CMD_PEEK, 8'h00, 6'd3, 7'd0);
    add_item(brb_pkg::CMD_PEEK, 8'h00, 6'd4, 7'd0);
    add_item(brb_pkg::CMD_PEEK, 8'h00, 6'd63, 7'd0);
    // A drop of nothing changes nothing.
    add_item(brb_pkg::CMD_DROP_FRONT, 8'h00, 6'd0, 7'd0);
    // Middle removal of one byte, of zero bytes, a run cut at the tail and a
    // start slot outside the held bytes.
    add_item(brb_pkg::CMD_REMOVE_MID, 8'h00, gen_ring.head + 1'b1, 7'd1);
    add_item(brb_pkg::CMD_REMOVE_MID, 8'h00, gen_ring.head + 1'b1, 7'd0);
    add_item(brb_pkg::CMD_REMOVE_MID, 8'h00, gen_ring.head + 1'b1, 7'd64);
    add_item(brb_pkg::CMD_REMOVE_MID, 8'h00, gen_ring.tail, 7'd1);
    add_item(CMD_UNUSED, 8'hFF, 6'd63, 7'd64);
    add_item(brb_pkg::CMD_POP_FRONT, 8'h00, 6'd0, 7'd0);
    // A drop larger than the fill level saturates.
    add_item(brb_pkg::CMD_PUSH_BACK, 8'h3C, 6'd0, 7'd0);
    add_item(brb_pkg::CMD_PUSH_BACK, 8'hC3, 6'd0, 7'd0);
    add_item(brb_pkg::CMD_DROP_FRONT, 8'h00, 6'd0, 7'd64);
    add_item(brb_pkg::CMD_PUSH_BACK, 8'h81, 6'd0, 7'd0);
    add_item(brb_pkg::CMD_CLEAR, 8'h00, 6'd0, 7'd0);
    add_item(brb_pkg::CMD_PUSH_FRONT, 8'h7E, 6'd63, 7'd64);

    // Random part. Traffic switches at random between filling, draining and mixed
    // spans so the ring runs up to full (where pushes are refused) and back
    // down to empty. Most offsets point into the held bytes; a share is
    // left fully random to hit the out-of-range cases.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % MODE_SPAN == 0) mode = $urandom_range(MODE_FILL, MODE_MIX);
      fill  = ring_fill(gen_ring);
      roll  = $urandom_range(0, 99);
      noise = ($urandom_range(0, 99) < 20);
      case (mode)
        MODE_FILL: begin
          if (roll < 60) op = brb_pkg::CMD_PUSH_BACK;
          else if (roll < 80) op = brb_pkg::CMD_PUSH_FRONT;
          else if (roll < 90) op = brb_pkg::CMD_PEEK;
          else if (roll < 95) op = brb_pkg::CMD_POP_FRONT;
          else if (roll < 98) op = brb_pkg::CMD_REMOVE_MID;
          else op = brb_pkg::CMD_DROP_FRONT;
        end
        MODE_DRAIN: begin
          if (roll < 30) op = brb_pkg::CMD_POP_FRONT;
          else if (roll < 50) op = brb_pkg::CMD_DROP_FRONT;
          else if (roll < 65) op = brb_pkg::CMD_REMOVE_MID;
          else if (roll < 80) op = brb_pkg::CMD_PEEK;
          else if (roll < 90) op = brb_pkg::CMD_PUSH_BACK;
          else op = brb_pkg::CMD_PUSH_FRONT;
        end
        default: begin
          if (roll < 20) op = brb_pkg::CMD_PUSH_BACK;
          else if (roll < 35) op = brb_pkg::CMD_PUSH_FRONT;
          else if (roll < 50) op = brb_pkg::CMD_POP_FRONT;
          else if (roll < 65) op = brb_pkg::CMD_PEEK;
          else if (roll < 77) op = brb_pkg::CMD_REMOVE_MID;
          else if (roll < 89) op = brb_pkg::CMD_DROP_FRONT;
          else if (roll < 97) op = brb_pkg::CMD_PUSH_BACK;
          else if (roll < 98) op = brb_pkg::CMD_CLEAR;
          else op = CMD_UNUSED;
        end
      endcase
      idx = SLOT_W'($urandom_range(0, DEPTH - 1));
      cnt = CNT_W'($urandom_range(0, DEPTH));
      if (op == brb_pkg::CMD_PEEK && fill > 0 && !noise) begin
        idx = SLOT_W'($urandom_range(0, fill - 1));
      end
      if (op == brb_pkg::CMD_REMOVE_MID && fill > 0 && !noise) begin
        idx = gen_ring.head + SLOT_W'($urandom_range(0, fill - 1));
      end
      if ((op == brb_pkg::CMD_REMOVE_MID || op == brb_pkg::CMD_DROP_FRONT) && !noise) begin
        cnt = CNT_W'($urandom_range(0, (mode == MODE_DRAIN) ? 12 : 3));
      end
      add_item(op, BYTE_W'($urandom_range(0, 255)), idx, cnt);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every command has been taken and every status has come
    // back, then give the block time to show any stray transaction.
    while (cmd_q.size() > 0 || in_valid || status_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
